// File: hdl/tsd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsd_pkg: shared types and constants of the threshold spike detector
// Field widths, register indexes, queue depths and the transaction structs
// that travel between the front end, the queues and the back end.
// ----------------------------------------------------------------------------
package tsd_pkg;

  localparam int NUM_CHANNELS_DEF = 64;
  localparam int CH_W       = 6;
  localparam int TIME_W     = 32;
  localparam int SMP_W      = 16;
  localparam int THR_W      = 15;
  localparam int THRSQ_W    = 31;
  localparam int CFG_DATA_W = 64;
  localparam int CFG_IDX_W  = 1;
  localparam int MID_DEPTH  = 4;
  localparam int OUT_DEPTH  = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ENABLE_MASK = 1'b0,
    CFG_TIME_ORIGIN = 1'b1
  } tsd_cfg_idx_t;

  // Classified sample handed from the front end to the back end
  typedef struct packed {
    logic [CH_W-1:0]         ch;
    logic [TIME_W-1:0]       t;
    logic signed [SMP_W-1:0] y;
    logic [THR_W-1:0]        thr;
    logic                    start_hit;
    logic                    end_hit;
  } tsd_item_t;

  // Per-channel spike record kept in the back end memory
  typedef struct packed {
    logic signed [SMP_W-1:0] ext_val;
    logic [TIME_W-1:0]       ext_time;
    logic [TIME_W-1:0]       start_time;
  } tsd_state_t;

  // Finished spike report
  typedef struct packed {
    logic [CH_W-1:0]         ch;
    logic [TIME_W-1:0]       peak_time;
    logic [TIME_W-1:0]       width;
    logic signed [SMP_W-1:0] height;
    logic [THR_W-1:0]        thr;
  } tsd_result_t;

endpackage

// File: hdl/tsd_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsd_fifo: small synchronous queue
// Flop-based first-in first-out buffer with full and empty flags.
// ----------------------------------------------------------------------------
module tsd_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] din,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] dout,
  output logic         empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  buf_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push, do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = buf_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      buf_r[wr_ptr_r] <= din;
    end
  end

endmodule

// File: hdl/tsd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsd_front: sample intake and classification
// Accepts samples, drops disabled or out-of-range channels, squares the
// sample and tags it with the start and end threshold tests.
// ----------------------------------------------------------------------------
module tsd_front
  import tsd_pkg::*;
#(
  parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_push,
  output logic                    in_full,
  input  logic [CH_W-1:0]         in_channel,
  input  logic [TIME_W-1:0]       in_sample_time,
  input  logic signed [SMP_W-1:0] in_filtered_sample,
  input  logic [THR_W-1:0]        in_threshold,
  input  logic [THRSQ_W-1:0]      in_threshold_squared,
  input  logic [CFG_DATA_W-1:0]   enable_mask,
  output logic                    item_vld,
  output tsd_item_t               item,
  input  logic                    item_rdy
);

  localparam int SQ_W = 2 * SMP_W - 1;
  localparam int PR_W = THRSQ_W + 3;

  logic                    s1_vld_r, s1_vld_nxt;
  logic [CH_W-1:0]         s1_ch_r;
  logic [TIME_W-1:0]       s1_t_r;
  logic signed [SMP_W-1:0] s1_y_r;
  logic [THR_W-1:0]        s1_thr_r;
  logic [THRSQ_W-1:0]      s1_thsq_r;
  logic [SQ_W-1:0]         s1_y2_r;

  logic                    accept, keep;
  logic [SMP_W-1:0]        ymag;
  logic [SQ_W-1:0]         y2;
  logic [PR_W-1:0]         y2x10, thsq7;

  assign in_full = s1_vld_r && !item_rdy;
  assign accept  = in_push && !in_full;
  assign keep    = (32'(in_channel) < NUM_CHANNELS) && enable_mask[in_channel];

  assign ymag = in_filtered_sample[SMP_W-1] ? SMP_W'(-in_filtered_sample)
                                            : SMP_W'(in_filtered_sample);
  assign y2   = SQ_W'({{(SQ_W-SMP_W){1'b0}}, ymag} * {{(SQ_W-SMP_W){1'b0}}, ymag});

  // Hysteresis end test in integers: y*y*10 < thr_sq*7
  assign y2x10 = (PR_W'(s1_y2_r) << 3) + (PR_W'(s1_y2_r) << 1);
  assign thsq7 = (PR_W'(s1_thsq_r) << 3) - PR_W'(s1_thsq_r);

  always_comb begin
    s1_vld_nxt = s1_vld_r;
    if (accept) begin
      s1_vld_nxt = keep;
    end else if (item_rdy) begin
      s1_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= s1_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_ch_r   <= in_channel;
      s1_t_r    <= in_sample_time;
      s1_y_r    <= in_filtered_sample;
      s1_thr_r  <= in_threshold;
      s1_thsq_r <= in_threshold_squared;
      s1_y2_r   <= y2;
    end
  end

  assign item_vld       = s1_vld_r;
  assign item.ch        = s1_ch_r;
  assign item.t         = s1_t_r;
  assign item.y         = s1_y_r;
  assign item.thr       = s1_thr_r;
  assign item.start_hit = (PR_W'(s1_y2_r) > PR_W'(s1_thsq_r));
  assign item.end_hit   = (y2x10 < thsq7);

endmodule

// File: hdl/tsd_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsd_back: per-channel spike tracking
// Two-stage read-modify-write of the per-channel spike record with a bypass
// for back-to-back samples of one channel; emits finished spikes.
// ----------------------------------------------------------------------------
module tsd_back
  import tsd_pkg::*;
#(
  parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              item_vld,
  input  tsd_item_t         item,
  output logic              item_pop,
  input  logic [TIME_W-1:0] time_origin,
  output logic              res_push,
  output tsd_result_t       res,
  input  logic              res_full
);

  localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  tsd_state_t              mem [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0] in_spike_r;
  logic [NUM_CHANNELS-1:0] neg_r;
  logic                    b_vld_r, b_vld_nxt;
  tsd_item_t               b_item_r;
  tsd_state_t              rd_data_r;
  logic                    byp_hit_r;
  tsd_state_t              byp_data_r;

  logic [IDX_W-1:0] idx_a, idx_b;
  tsd_state_t       cur, wr_data;
  logic             ins, neg, beyond;
  logic             wr_en, set_spike, clr_spike, emit;
  logic             a_fire, b_fire;

  assign idx_a = item.ch[IDX_W-1:0];
  assign idx_b = b_item_r.ch[IDX_W-1:0];

  // Take the record written last cycle if the memory read missed it
  assign cur    = byp_hit_r ? byp_data_r : rd_data_r;
  assign ins    = in_spike_r[idx_b];
  assign neg    = neg_r[idx_b];
  assign beyond = neg ? (b_item_r.y < cur.ext_val) : (b_item_r.y > cur.ext_val);

  always_comb begin
    wr_en              = 1'b0;
    set_spike          = 1'b0;
    clr_spike          = 1'b0;
    emit               = 1'b0;
    wr_data.ext_val    = b_item_r.y;
    wr_data.ext_time   = b_item_r.t;
    wr_data.start_time = cur.start_time;
    if (!ins) begin
      if (b_item_r.start_hit) begin
        set_spike          = 1'b1;
        wr_en              = 1'b1;
        wr_data.start_time = b_item_r.t;
      end
    end else if (beyond) begin
      wr_en = 1'b1;
    end else if (b_item_r.end_hit) begin
      emit      = 1'b1;
      clr_spike = 1'b1;
    end
  end

  assign b_fire   = b_vld_r && !(emit && res_full);
  assign a_fire   = item_vld && (!b_vld_r || b_fire);
  assign item_pop = a_fire;
  assign res_push = b_vld_r && emit && !res_full;

  assign res.ch        = b_item_r.ch;
  assign res.peak_time = cur.ext_time - time_origin;
  assign res.width     = b_item_r.t - cur.start_time;
  assign res.height    = cur.ext_val;
  assign res.thr       = b_item_r.thr;

  always_comb begin
    b_vld_nxt = b_vld_r;
    if (a_fire) begin
      b_vld_nxt = 1'b1;
    end else if (b_fire) begin
      b_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r    <= 1'b0;
      in_spike_r <= '0;
      neg_r      <= '0;
    end else begin
      b_vld_r <= b_vld_nxt;
      if (b_fire && set_spike) begin
        in_spike_r[idx_b] <= 1'b1;
        neg_r[idx_b]      <= b_item_r.y[SMP_W-1];
      end
      if (b_fire && clr_spike) begin
        in_spike_r[idx_b] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (b_fire && wr_en) begin
      mem[idx_b] <= wr_data;
    end
    if (a_fire) begin
      rd_data_r  <= mem[idx_a];
      b_item_r   <= item;
      byp_hit_r  <= b_fire && wr_en && (idx_b == idx_a);
      byp_data_r <= wr_data;
    end
  end

endmodule

// File: hdl/threshold_spike_detector.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// threshold_spike_detector: per-channel threshold spike detection
// Hysteresis spike detector over an interleaved multi-channel sample stream.
// ----------------------------------------------------------------------------
// Push one band-passed sample per cycle, of any channel in any interleaving;
// the block sustains one sample per clock while in_full is low. A sample
// passes a squaring register, a four-entry queue and a per-channel
// read-modify-write of the spike record (a memory with one read and one
// write port and a bypass lets a channel repeat in consecutive cycles);
// the record stage pushes a spike report into the result queue when its
// ending sample completes. Only a full result queue, left unpopped, slows
// intake. Samples of disabled channels or channels at or beyond NUM_CHANNELS
// are taken and dropped. Write configuration only while the block is idle.
// ----------------------------------------------------------------------------
module threshold_spike_detector
  import tsd_pkg::*;
#(
  parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  // sample transactions
  input  logic                    in_push,
  output logic                    in_full,
  input  logic [CH_W-1:0]         in_channel,
  input  logic [TIME_W-1:0]       in_sample_time,
  input  logic signed [SMP_W-1:0] in_filtered_sample,
  input  logic [THR_W-1:0]        in_threshold,
  input  logic [THRSQ_W-1:0]      in_threshold_squared,
  // spike report transactions
  output logic                    out_empty,
  input  logic                    out_pop,
  output logic [CH_W-1:0]         out_spike_channel,
  output logic [TIME_W-1:0]       out_peak_time,
  output logic [TIME_W-1:0]       out_spike_width,
  output logic signed [SMP_W-1:0] out_spike_height,
  output logic [THR_W-1:0]        out_spike_threshold,
  // configuration writes
  input  logic                    cfg_we,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data
);

  localparam int ITEM_W = $bits(tsd_item_t);
  localparam int RES_W  = $bits(tsd_result_t);

  logic [CFG_DATA_W-1:0] enable_mask_r;
  logic [TIME_W-1:0]     time_origin_r;

  logic        fr_vld, mid_full, mid_empty, mid_pop;
  tsd_item_t   fr_item, mid_item;
  logic        res_push, out_full;
  tsd_result_t res, out_res;

  // Configuration registers: enable mask and peak-time origin
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_mask_r <= '0;
      time_origin_r <= '0;
    end else if (cfg_we) begin
      if (cfg_index == CFG_ENABLE_MASK) begin
        enable_mask_r <= cfg_data;
      end else if (cfg_index == CFG_TIME_ORIGIN) begin
        time_origin_r <= cfg_data[TIME_W-1:0];
      end
    end
  end

  // Front end: take, filter by channel, square and classify
  tsd_front #(
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_front (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_push              (in_push),
    .in_full              (in_full),
    .in_channel           (in_channel),
    .in_sample_time       (in_sample_time),
    .in_filtered_sample   (in_filtered_sample),
    .in_threshold         (in_threshold),
    .in_threshold_squared (in_threshold_squared),
    .enable_mask          (enable_mask_r),
    .item_vld             (fr_vld),
    .item                 (fr_item),
    .item_rdy             (!mid_full)
  );

  // Decouple the front end from back-end stalls
  tsd_fifo #(
    .W     (ITEM_W),
    .DEPTH (MID_DEPTH)
  ) u_mid_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (fr_vld),
    .din   (fr_item),
    .full  (mid_full),
    .pop   (mid_pop),
    .dout  (mid_item),
    .empty (mid_empty)
  );

  // Back end: per-channel spike state and report generation
  tsd_back #(
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .item_vld    (!mid_empty),
    .item        (mid_item),
    .item_pop    (mid_pop),
    .time_origin (time_origin_r),
    .res_push    (res_push),
    .res         (res),
    .res_full    (out_full)
  );

  // Hold finished reports until the consumer pops them
  tsd_fifo #(
    .W     (RES_W),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .din   (res),
    .full  (out_full),
    .pop   (out_pop),
    .dout  (out_res),
    .empty (out_empty)
  );

  assign out_spike_channel   = out_res.ch;
  assign out_peak_time       = out_res.peak_time;
  assign out_spike_width     = out_res.width;
  assign out_spike_height    = out_res.height;
  assign out_spike_threshold = out_res.thr;

  // Never lose a report into a full result queue
  a_res_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> !out_full)
    else $error("spike report pushed into full result queue");

  // Never pop an empty middle queue
  a_mid_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    mid_pop |-> !mid_empty)
    else $error("back end popped empty sample queue");

  // Reset leaves no report pending
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> out_empty)
    else $error("result queue not empty after reset");

endmodule
